FILE: rtl/core/hpt_pkg.sv
// -----------------------------------------------------------------------------
// hpt_pkg
// Shared constants and stage types of the homogeneous point transform.
// -----------------------------------------------------------------------------
package hpt_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FracBitsDef = 16;

  localparam int CoordW  = 32;
  localparam int CfgW    = 64;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 4;
  localparam int RegSelW = $clog2(NumRegs);

  // Exact product, exact row sum, magnitude and quotient widths.
  localparam int ProdW = 2 * CoordW;
  localparam int AccW  = ProdW + 2;
  localparam int MagW  = 64;
  localparam int QuotW = CoordW + 1;
  localparam int NumDivSteps = QuotW;

  // Command codes.
  localparam logic CmdPoint = 1'b0;
  localparam logic CmdDir   = 1'b1;

  // Products of all four rows, plus the column-3 entries.
  typedef struct packed {
    logic                            point;
    logic [3:0][2:0][ProdW-1:0]      prod;
    logic [3:0][CoordW-1:0]          trans;
  } prod_t;

  // Row sums already reduced to the fixed-point format (rows 0..2 and w).
  typedef struct packed {
    logic                 point;
    logic [3:0][AccW-1:0] sum;
  } sum_t;

  // State of the three restoring dividers, one lane per coordinate.
  typedef struct packed {
    logic                  divided;
    logic [2:0]            neg;
    logic [2:0]            big;
    logic [2:0][MagW-1:0]  rem;
    logic [MagW-1:0]       den;
    logic [2:0][QuotW-1:0] quot;
  } div_t;

endpackage

FILE: rtl/core/hpt_if.sv
// -----------------------------------------------------------------------------
// hpt_if
// Request and response channels of the homogeneous point transform.
// -----------------------------------------------------------------------------
interface hpt_req_if;
  logic                valid;
  logic                ready;
  logic                command;
  logic signed [31:0]  in_x;
  logic signed [31:0]  in_y;
  logic signed [31:0]  in_z;

  modport source (output valid, command, in_x, in_y, in_z, input ready);
  modport sink   (input valid, command, in_x, in_y, in_z, output ready);
endinterface

interface hpt_rsp_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  out_x;
  logic signed [31:0]  out_y;
  logic signed [31:0]  out_z;
  logic                was_divided;
  logic                overflow;

  modport source (output valid, out_x, out_y, out_z, was_divided, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, was_divided, overflow, output ready);
endinterface

FILE: rtl/core/hpt_mac.sv
// -----------------------------------------------------------------------------
// hpt_mac
// Two stages: twelve 32x32 products, then the exact row sums floored to the
// fixed-point format.
// -----------------------------------------------------------------------------
module hpt_mac import hpt_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hpt_req_if.sink                        in_i,
  input  logic [3:0][3:0][CoordW-1:0]    mat_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sum_t                           out_data_o
);

  logic  en;
  logic  va_q, vb_q;
  prod_t pa_d, pa_q;
  sum_t  sb_d, sb_q;
  logic [2:0][CoordW-1:0] crd;

  // The two stages move together when the last one can hand off.
  assign en         = !vb_q || out_ready_i;
  assign in_i.ready = en;

  // Products of every matrix entry with the matching coordinate.
  always_comb begin
    crd[0]   = in_i.in_x;
    crd[1]   = in_i.in_y;
    crd[2]   = in_i.in_z;
    pa_d.point = (in_i.command == CmdPoint);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa_d.prod[r][c] = ProdW'($signed(mat_i[r][c])) * ProdW'($signed(crd[c]));
      end
      pa_d.trans[r] = mat_i[r][3];
    end
  end

  // Exact row sums, translation added in point mode, then floored.
  always_comb begin
    logic signed [AccW-1:0] acc;
    acc = '0;
    sb_d.point = pa_q.point;
    for (int r = 0; r < 4; r++) begin
      acc = AccW'($signed(pa_q.prod[r][0])) + AccW'($signed(pa_q.prod[r][1]))
          + AccW'($signed(pa_q.prod[r][2]));
      if (pa_q.point) begin
        acc = acc + (AccW'($signed(pa_q.trans[r])) <<< FRAC_BITS);
      end
      sb_d.sum[r] = acc >>> FRAC_BITS;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= pa_d;
      sb_q <= sb_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = sb_q;

endmodule

FILE: rtl/core/hpt_div.sv
// -----------------------------------------------------------------------------
// hpt_div
// Divide setup and three restoring dividers, one quotient bit per stage.
// Undivided coordinates pass through with a divisor of one.
// -----------------------------------------------------------------------------
module hpt_div import hpt_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sum_t  in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output div_t  out_data_o
);

  localparam int CmpW = MagW + QuotW;
  localparam logic [AccW-1:0] OneFx = AccW'(1) << FRAC_BITS;

  logic                 en;
  logic [NumDivSteps:0] vld_q;
  div_t                 st0_d;
  div_t                 st_d [1:NumDivSteps];
  div_t                 st_q [NumDivSteps+1];

  assign en         = !vld_q[NumDivSteps] || out_ready_i;
  assign in_ready_o = en;

  // Setup: decide on the divide, take magnitudes and the result sign.
  always_comb begin
    logic [AccW-1:0] wv;
    logic [AccW-1:0] vv;
    logic [AccW-1:0] av;
    logic [AccW-1:0] aw;
    wv = in_data_i.sum[3];
    aw = wv[AccW-1] ? AccW'(-wv) : wv;
    st0_d.divided = in_data_i.point && (wv != '0) && (wv != OneFx);
    st0_d.den     = st0_d.divided ? MagW'(aw) : MagW'(1);
    st0_d.quot    = '0;
    for (int i = 0; i < 3; i++) begin
      vv = in_data_i.sum[i];
      av = vv[AccW-1] ? AccW'(-vv) : vv;
      if (st0_d.divided) begin
        st0_d.rem[i] = MagW'(av) << FRAC_BITS;
        st0_d.neg[i] = vv[AccW-1] ^ wv[AccW-1];
      end else begin
        st0_d.rem[i] = MagW'(av);
        st0_d.neg[i] = vv[AccW-1];
      end
      // A quotient at or above the bit range saturates later.
      st0_d.big[i] = {{QuotW{1'b0}}, st0_d.rem[i]} >= {st0_d.den, {QuotW{1'b0}}};
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  always_comb begin
    logic [CmpW-1:0] sub;
    sub = '0;
    for (int s = 1; s <= NumDivSteps; s++) begin
      st_d[s] = st_q[s-1];
      for (int i = 0; i < 3; i++) begin
        sub = {{QuotW{1'b0}}, st_q[s-1].den} << (NumDivSteps - s);
        if ({{QuotW{1'b0}}, st_q[s-1].rem[i]} >= sub) begin
          st_d[s].rem[i] = st_q[s-1].rem[i] - MagW'(sub);
          st_d[s].quot[i][NumDivSteps-s] = 1'b1;
        end
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumDivSteps-1:0], in_valid_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0_d;
      for (int s = 1; s <= NumDivSteps; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign out_valid_o = vld_q[NumDivSteps];
  assign out_data_o  = st_q[NumDivSteps];

endmodule

FILE: rtl/core/hpt_sat.sv
// -----------------------------------------------------------------------------
// hpt_sat
// Applies the sign, saturates to 32 bits and holds the response register.
// -----------------------------------------------------------------------------
module hpt_sat import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  div_t       in_data_i,
  hpt_rsp_if.source  out_o
);

  localparam logic [QuotW-1:0]  NegLim = QuotW'(1) << (CoordW - 1);
  localparam logic [QuotW-1:0]  PosLim = NegLim - QuotW'(1);
  localparam logic [CoordW-1:0] MaxVal = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] MinVal = {1'b1, {(CoordW-1){1'b0}}};

  logic                   v_q;
  logic [2:0][CoordW-1:0] res_d, res_q;
  logic                   ovf_d, ovf_q;
  logic                   div_q;

  assign in_ready_o = !v_q || out_o.ready;

  // Signed result with saturation per coordinate.
  always_comb begin
    logic sat;
    sat   = 1'b0;
    ovf_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sat = in_data_i.big[i] ||
            (in_data_i.neg[i] ? (in_data_i.quot[i] > NegLim) : (in_data_i.quot[i] > PosLim));
      if (sat) begin
        res_d[i] = in_data_i.neg[i] ? MinVal : MaxVal;
      end else if (in_data_i.neg[i]) begin
        res_d[i] = CoordW'(-in_data_i.quot[i]);
      end else begin
        res_d[i] = CoordW'(in_data_i.quot[i]);
      end
      ovf_d = ovf_d | sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
      div_q <= in_data_i.divided;
    end
  end

  assign out_o.valid       = v_q;
  assign out_o.out_x       = res_q[0];
  assign out_o.out_y       = res_q[1];
  assign out_o.out_z       = res_q[2];
  assign out_o.was_divided = div_q;
  assign out_o.overflow    = ovf_q;

endmodule

FILE: rtl/core/homogeneous_point_transform.sv
// -----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 fixed-point transform of a point or direction with perspective divide.
//
//   Channel   Dir   Signals                                Handshake
//   in_i      in    command, in_x, in_y, in_z              valid/ready
//   out_o     out   out_x, out_y, out_z, was_divided,      valid/ready
//                   overflow
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_data_i        write enable only
//
// One request per cycle while no stall holds the pipeline; the pipeline is 37
// registers deep: two multiply-add stages, the divide setup, 33 restoring
// divider stages (one quotient bit each) and the response register. The divider
// stages make up most of the pipeline depth.
// Reset loads the identity matrix and clears all valid bits.
// A stall freezes each section whose last stage is full; a section whose last
// stage is empty keeps moving.
// -----------------------------------------------------------------------------
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hpt_req_if.sink            in_i,
  hpt_rsp_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam logic [CoordW-1:0] One = CoordW'(1) << FRAC_BITS;

  logic [CfgW-1:0]             regs_q [NumRegs];
  logic [3:0][3:0][CoordW-1:0] mat;
  logic                        mac_valid, mac_ready;
  sum_t                        mac_data;
  logic                        div_valid, div_ready;
  div_t                        div_data;

  // Matrix registers, identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= {{CoordW{1'b0}}, One};
      regs_q[1] <= '0;
      regs_q[2] <= {One, {CoordW{1'b0}}};
      regs_q[3] <= '0;
      regs_q[4] <= '0;
      regs_q[5] <= {{CoordW{1'b0}}, One};
      regs_q[6] <= '0;
      regs_q[7] <= {One, {CoordW{1'b0}}};
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_idx_i[RegSelW-1:0]] <= cfg_data_i;
    end
  end

  // Unpack two entries per register.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs_q[r*2 + c/2][(c%2)*CoordW +: CoordW];
      end
    end
  end

  hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mat_i       (mat),
    .out_valid_o (mac_valid),
    .out_ready_i (mac_ready),
    .out_data_o  (mac_data)
  );

  hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mac_valid),
    .in_ready_o  (mac_ready),
    .in_data_i   (mac_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  hpt_sat u_sat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .in_data_i  (div_data),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  // An overflow always leaves some coordinate at a range limit.
  a_ovf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflow |->
      (out_o.out_x == 32'sh7fffffff) || (out_o.out_x == -32'sh80000000) ||
      (out_o.out_y == 32'sh7fffffff) || (out_o.out_y == -32'sh80000000) ||
      (out_o.out_z == 32'sh7fffffff) || (out_o.out_z == -32'sh80000000))
    else $error("overflow without a saturated coordinate");

  // Requests are refused only while a response is held back.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("request refused without a response stall");

  // No response is offered during reset.
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_o.valid)
    else $error("response valid during reset");
`endif

endmodule

FILE: sim/tb_homogeneous_point_transform.sv
// -----------------------------------------------------------------------------
// tb_homogeneous_point_transform
// Self-checking testbench of the 4x4 homogeneous point transform.
// Requests are driven with random gaps, responses are taken with random
// stalls, and every response is compared with a fixed-point prediction made
// when its request is accepted. Matrix settings change only while idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_homogeneous_point_transform import hpt_pkg::*; ();

  localparam int Frac = FracBitsDef;
  localparam int DrainCycles = 60;
  localparam logic signed [31:0] OneFx = 32'sd1 <<< Frac;
  localparam logic signed [31:0] MaxFx = 32'sh7fffffff;
  localparam logic signed [31:0] MinFx = 32'sh80000000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               divided;
    logic               ovf;
  } coord_out_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  hpt_req_if req_if ();
  hpt_rsp_if rsp_if ();

  homogeneous_point_transform i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if.sink),
    .out_o      (rsp_if.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Matrix shadow registers and the queue of pending transformed points.
  logic [CfgW-1:0] mat_regs[NumRegs];
  coord_out_t      pending_pts[$];
  int unsigned     fail_cnt;
  bit              quiet;
  bit              rsp_taken;
  int unsigned     stall_left;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #2ms;
    $display("homogeneous_point_transform verification failed");
    $finish;
  end

  function automatic logic signed [31:0] mat_entry(int r, int c);
    return mat_regs[r * 2 + c / 2][(c % 2) * 32 +: 32];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return MaxFx;
    end else if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return MinFx;
    end
    return v[31:0];
  endfunction

  // Exact row sums, floor to the fixed-point format, optional divide by w.
  function automatic coord_out_t predict_xform(logic cmd, logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz);
    logic signed [127:0] acc;
    logic signed [127:0] e;
    logic signed [127:0] v[4];
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    logic                point;
    logic                ovf;
    coord_out_t          res;
    point = (cmd == CmdPoint);
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      e = mat_entry(r, 0); acc += e * px;
      e = mat_entry(r, 1); acc += e * py;
      e = mat_entry(r, 2); acc += e * pz;
      if (point) begin
        e = mat_entry(r, 3);
        acc += e <<< Frac;
      end
      v[r] = acc >>> Frac;
    end
    res.divided = point && (v[3] != 0) && (v[3] != (128'sd1 <<< Frac));
    if (res.divided) begin
      den = (v[3] < 0) ? -v[3] : v[3];
      for (int i = 0; i < 3; i++) begin
        num = (v[i] < 0) ? -v[i] : v[i];
        q = (num <<< Frac) / den;
        v[i] = ((v[i] < 0) != (v[3] < 0)) ? -q : q;
      end
    end
    ovf = 1'b0;
    res.x = clamp32(v[0], ovf);
    res.y = clamp32(v[1], ovf);
    res.z = clamp32(v[2], ovf);
    res.ovf = ovf;
    return res;
  endfunction

  // Response ready with a random stall after each accepted response.
  always @(negedge clk_i) begin
    if (rsp_taken) begin
      rsp_taken = 1'b0;
      stall_left = quiet ? 0 : $urandom_range(0, 6);
    end
    rsp_if.ready <= (stall_left == 0);
    if (stall_left > 0) stall_left--;
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk_i) begin
    coord_out_t exp_pt;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_taken = 1'b1;
      if (pending_pts.size() == 0) begin
        $error("unexpected response x=%0d y=%0d z=%0d", rsp_if.out_x, rsp_if.out_y,
               rsp_if.out_z);
        fail_cnt++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (rsp_if.out_x !== exp_pt.x) begin
          $error("out_x expected %0d actual %0d", exp_pt.x, rsp_if.out_x);
          fail_cnt++;
        end
        if (rsp_if.out_y !== exp_pt.y) begin
          $error("out_y expected %0d actual %0d", exp_pt.y, rsp_if.out_y);
          fail_cnt++;
        end
        if (rsp_if.out_z !== exp_pt.z) begin
          $error("out_z expected %0d actual %0d", exp_pt.z, rsp_if.out_z);
          fail_cnt++;
        end
        if (rsp_if.was_divided !== exp_pt.divided) begin
          $error("was_divided expected %0b actual %0b", exp_pt.divided, rsp_if.was_divided);
          fail_cnt++;
        end
        if (rsp_if.overflow !== exp_pt.ovf) begin
          $error("overflow expected %0b actual %0b", exp_pt.ovf, rsp_if.overflow);
          fail_cnt++;
        end
      end
    end
  end

  // Send one request; called at a falling edge and returns at one.
  task automatic send_point(logic cmd, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.in_x    <= px;
    req_if.in_y    <= py;
    req_if.in_z    <= pz;
    do @(posedge clk_i); while (!req_if.ready);
    pending_pts.push_back(predict_xform(cmd, px, py, pz));
    @(negedge clk_i);
  endtask

  // Stop sending and let the pipeline drain before a register write.
  task automatic drain();
    req_if.valid <= 1'b0;
    wait (pending_pts.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Drive a write on the write port, then return the port to idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx < CfgIdxW'(NumRegs)) mat_regs[idx[RegSelW-1:0]] = data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_row(int r, logic signed [31:0] c0, logic signed [31:0] c1,
                           logic signed [31:0] c2, logic signed [31:0] c3);
    write_reg(CfgIdxW'(2 * r), {c1, c0});
    write_reg(CfgIdxW'(2 * r + 1), {c3, c2});
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom_range(0, 1) ? MaxFx : MinFx;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_entry(int kind);
    case (kind)
      0: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
      1: return $urandom;
      default: return $urandom_range(0, 1) ? MaxFx : MinFx;
    endcase
  endfunction

  // Identity after reset, extreme coordinates in both modes.
  task automatic test_reset_identity();
    send_point(CmdPoint, 32'sh00010000, 32'sh00020000, -32'sh00030000);
    send_point(CmdPoint, MaxFx, MinFx, 0);
    send_point(CmdDir, MinFx, MaxFx, -1);
    send_point(CmdDir, 0, 0, 0);
    send_point(CmdPoint, -1, 1, MaxFx);
  endtask

  // Zero w, unit w, divide by two, w from z of either sign, and translation ignored by directions.
  task automatic test_w_cases();
    drain();
    write_row(0, OneFx, 0, 0, 32'sh00050000);
    write_row(3, 0, 0, 0, 0);
    send_point(CmdPoint, 32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_point(CmdDir, 32'sh00010000, 32'sh00020000, 32'sh00030000);
    drain();
    write_row(3, 0, 0, 0, OneFx);
    send_point(CmdPoint, 32'sh00010000, -32'sh00020000, 32'sh00030000);
    drain();
    write_row(3, 0, 0, 0, 32'sh00020000);
    send_point(CmdPoint, 32'sh00030001, -32'sh00030001, 32'sh00070000);
    send_point(CmdDir, 32'sh00030001, -32'sh00030001, 32'sh00070000);
    drain();
    write_row(3, 0, 0, -OneFx, 0);
    send_point(CmdPoint, 32'sh00010000, 32'sh00020000, 32'sh00040000);
    send_point(CmdPoint, 32'sh00010000, 32'sh00020000, -32'sh00040000);
    send_point(CmdPoint, 32'sh00010000, 32'sh00020000, 0);
  endtask

  // A tiny w of either sign drives the quotient far beyond the coordinate range; a row of extremes follows.
  task automatic test_huge_quotient();
    drain();
    write_row(3, 0, 0, 0, 32'sd1);
    send_point(CmdPoint, MaxFx, MinFx, 32'sh00010000);
    drain();
    write_row(3, 0, 0, 0, -32'sd1);
    send_point(CmdPoint, MaxFx, MinFx, MinFx);
    drain();
    write_row(3, MinFx, MaxFx, MinFx, MaxFx);
    send_point(CmdPoint, MaxFx, MaxFx, MinFx);
  endtask

  // Writes beyond the last register leave the matrix untouched.
  task automatic test_bad_index();
    drain();
    for (int i = NumRegs; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), {$urandom, $urandom});
    send_point(CmdPoint, 32'sh00012345, -32'sh00054321, 32'sh00020000);
    send_point(CmdDir, 32'sh00012345, -32'sh00054321, 32'sh00020000);
  endtask

  // Random matrices: small, full range, extremes and perspective rows.
  task automatic test_random(int phases, int per_phase);
    int kind;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      kind = ph % 4;
      quiet = (ph % 5 == 4);
      for (int r = 0; r < 4; r++)
        write_row(r, rand_entry(kind % 3), rand_entry(kind % 3), rand_entry(kind % 3),
                  rand_entry(kind % 3));
      if (kind == 3)
        write_row(3, 0, 0, $urandom_range(0, 1) ? -OneFx : OneFx, rand_entry(0));
      for (int n = 0; n < per_phase; n++)
        send_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord());
    end
    quiet = 1'b0;
  endtask

  initial begin
    fail_cnt = 0;
    quiet = 1'b0;
    rsp_taken = 1'b0;
    stall_left = 0;
    req_if.valid = 1'b0;
    req_if.command = CmdPoint;
    req_if.in_x = '0;
    req_if.in_y = '0;
    req_if.in_z = '0;
    rsp_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    mat_regs[0] = 64'(OneFx);
    mat_regs[1] = '0;
    mat_regs[2] = 64'(OneFx) << 32;
    mat_regs[3] = '0;
    mat_regs[4] = '0;
    mat_regs[5] = 64'(OneFx);
    mat_regs[6] = '0;
    mat_regs[7] = 64'(OneFx) << 32;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_identity();
    test_w_cases();
    test_huge_quotient();
    test_bad_index();
    test_random(10, 125);

    drain();
    if (fail_cnt == 0 && pending_pts.size() == 0) begin
      $display("homogeneous_point_transform verification clean");
    end else begin
      $display("homogeneous_point_transform verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_if.sv
rtl/core/hpt_mac.sv
rtl/core/hpt_div.sv
rtl/core/hpt_sat.sv
rtl/core/homogeneous_point_transform.sv
sim/tb_homogeneous_point_transform.sv
